FILE: rtl/dfq_pkg.sv
package dfq_pkg;

  localparam int unsigned MAX_LOG2_DEF = 10;

  localparam int unsigned SYM_W   = 2;
  localparam int unsigned SIZE_W  = 4;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned SIDE_W  = 4;
  localparam int unsigned QUAD_W  = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd2;

  // Symbol codes; the unused code decodes as a white leaf.
  localparam logic [SYM_W-1:0] SYM_WHITE = 2'd0;
  localparam logic [SYM_W-1:0] SYM_BLACK = 2'd1;
  localparam logic [SYM_W-1:0] SYM_SPLIT = 2'd2;

  // Quadrant order: top-left, top-right, bottom-left, bottom-right.
  localparam logic [QUAD_W-1:0] QUAD_FIRST = 2'b00;
  localparam logic [QUAD_W-1:0] QUAD_LAST  = 2'b11;

  typedef struct packed {
    logic               black_block;
    logic [COORD_W-1:0] block_row;
    logic [COORD_W-1:0] block_col;
    logic [SIDE_W-1:0]  block_side_log2;
    logic               image_done;
    logic               all_white;
    logic               split_error;
  } blk_t;

endpackage

FILE: rtl/dfq_sym_if.sv
interface dfq_sym_if;
  import dfq_pkg::*;

  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink (input valid, input symbol, output ready);
endinterface

FILE: rtl/dfq_blk_if.sv
interface dfq_blk_if;
  import dfq_pkg::*;

  logic               valid;
  logic               ready;
  logic               black_block;
  logic [COORD_W-1:0] block_row;
  logic [COORD_W-1:0] block_col;
  logic [SIDE_W-1:0]  block_side_log2;
  logic               image_done;
  logic               all_white;
  logic               split_error;

  modport source (
    output valid, output black_block, output block_row, output block_col,
    output block_side_log2, output image_done, output all_white, output split_error,
    input ready
  );
  modport sink (
    input valid, input black_block, input block_row, input block_col,
    input block_side_log2, input image_done, input all_white, input split_error,
    output ready
  );
endinterface

FILE: rtl/dfq_step.sv
module dfq_step #(
  parameter int unsigned MAX_LOG2 = dfq_pkg::MAX_LOG2_DEF,
  parameter int unsigned LVL_W    = $clog2(MAX_LOG2 + 1)
) (
  input  logic [dfq_pkg::SYM_W-1:0]  symbol_i,
  input  logic [LVL_W-1:0]           lg_i,
  input  logic [LVL_W-1:0]           level_i,
  input  logic                       seen_i,
  input  logic [dfq_pkg::QUAD_W-1:0] stack_i [MAX_LOG2],
  output logic [dfq_pkg::QUAD_W-1:0] stack_o [MAX_LOG2],
  output logic [LVL_W-1:0]           level_o,
  output logic                       seen_o,
  output dfq_pkg::blk_t              res_o
);
  import dfq_pkg::*;

  localparam int unsigned RC_W = (MAX_LOG2 > COORD_W) ? MAX_LOG2 : COORD_W;
  localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_LOG2);

  logic             do_split;
  logic             is_black;
  logic [RC_W-1:0]  row_raw;
  logic [RC_W-1:0]  col_raw;
  logic [RC_W-1:0]  row_sh;
  logic [RC_W-1:0]  col_sh;
  logic [LVL_W-1:0] pop_lvl;
  logic             closes;

  assign do_split = (symbol_i == SYM_SPLIT) && (level_i < lg_i);
  assign is_black = (symbol_i == SYM_BLACK);

  // Quadrant at depth d supplies bit lg-1-d; assemble MSB-aligned, then shift down.
  always_comb begin
    row_raw = '0;
    col_raw = '0;
    for (int d = 0; d < MAX_LOG2; d++) begin
      if (LVL_W'(d) < level_i) begin
        row_raw[MAX_LOG2-1-d] = stack_i[d][1];
        col_raw[MAX_LOG2-1-d] = stack_i[d][0];
      end
    end
  end

  assign row_sh = row_raw >> (MAX_LVL - lg_i);
  assign col_sh = col_raw >> (MAX_LVL - lg_i);

  // Pop finished quadrants: deepest open level whose quadrant is not the last one.
  always_comb begin
    pop_lvl = '0;
    for (int t = 1; t <= MAX_LOG2; t++) begin
      if (LVL_W'(t) <= level_i && stack_i[t-1] != QUAD_LAST) begin
        pop_lvl = LVL_W'(t);
      end
    end
  end

  assign closes = !do_split && (pop_lvl == '0);

  always_comb begin
    stack_o = stack_i;
    level_o = level_i;
    seen_o  = seen_i;
    if (do_split) begin
      for (int d = 0; d < MAX_LOG2; d++) begin
        if (LVL_W'(d) == level_i) begin
          stack_o[d] = QUAD_FIRST;
        end
      end
      level_o = level_i + 1'b1;
    end else if (closes) begin
      level_o = '0;
      seen_o  = 1'b0;
    end else begin
      for (int d = 0; d < MAX_LOG2; d++) begin
        if (LVL_W'(d + 1) == pop_lvl) begin
          stack_o[d] = stack_i[d] + 1'b1;
        end
      end
      level_o = pop_lvl;
      seen_o  = seen_i || is_black;
    end
  end

  always_comb begin
    res_o                 = '0;
    res_o.split_error     = (symbol_i == SYM_SPLIT) && !do_split;
    res_o.image_done      = closes;
    res_o.all_white       = closes && !seen_i && !is_black;
    if (is_black) begin
      res_o.black_block     = 1'b1;
      res_o.block_row       = COORD_W'(row_sh);
      res_o.block_col       = COORD_W'(col_sh);
      res_o.block_side_log2 = SIDE_W'(lg_i - level_i);
    end
  end

endmodule

FILE: rtl/df_expression_quadtree_decoder.sv
// Channel  | Dir | Word                      | Handshake
// sym_i    | in  | symbol                    | valid/ready
// blk_o    | out | block, done and error word| valid/ready
// cfg      | in  | size_log2                 | cfg_we_i strobe, no wait
//
// One symbol per cycle unless blk_o stalls; each accepted symbol yields one output word on the next cycle.
// Tree state is updated at the accept edge by one pass of the step logic (a priority
// search over the quadrant stack for the pop), so symbols may arrive back to back.
// A stalled output word holds in the output register; sym_i stays ready while the
// word is being taken. Reset sets size_log2 to 2 and an empty tree; a size write
// also restarts the tree.
module df_expression_quadtree_decoder #(
  parameter int unsigned MAX_LOG2 = dfq_pkg::MAX_LOG2_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [dfq_pkg::SIZE_W-1:0] cfg_data_i,
  dfq_sym_if.sink                    sym_i,
  dfq_blk_if.source                  blk_o
);
  import dfq_pkg::*;

  localparam int unsigned LVL_W = $clog2(MAX_LOG2 + 1);
  localparam logic [LVL_W-1:0] LG_RESET =
    (32'(SIZE_RESET) > MAX_LOG2) ? LVL_W'(MAX_LOG2) : LVL_W'(SIZE_RESET);

  logic [LVL_W-1:0]  lg_q;
  logic [LVL_W-1:0]  lg_wr;
  logic [LVL_W-1:0]  level_q, level_d;
  logic              seen_q, seen_d;
  logic [QUAD_W-1:0] stack_q [MAX_LOG2];
  logic [QUAD_W-1:0] stack_d [MAX_LOG2];
  blk_t              res;
  blk_t              blk_q;
  logic              blk_valid_q;
  logic              in_fire;

  assign sym_i.ready = !blk_valid_q || blk_o.ready;
  assign in_fire     = sym_i.valid && sym_i.ready;

  // Saturate the written size to the stack depth.
  assign lg_wr = (32'(cfg_data_i) > MAX_LOG2) ? LVL_W'(MAX_LOG2) : LVL_W'(cfg_data_i);

  dfq_step #(
    .MAX_LOG2 (MAX_LOG2),
    .LVL_W    (LVL_W)
  ) u_step (
    .symbol_i (sym_i.symbol),
    .lg_i     (lg_q),
    .level_i  (level_q),
    .seen_i   (seen_q),
    .stack_i  (stack_q),
    .stack_o  (stack_d),
    .level_o  (level_d),
    .seen_o   (seen_d),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lg_q    <= LG_RESET;
      level_q <= '0;
      seen_q  <= 1'b0;
      for (int d = 0; d < MAX_LOG2; d++) begin
        stack_q[d] <= QUAD_FIRST;
      end
    end else if (cfg_we_i) begin
      lg_q    <= lg_wr;
      level_q <= '0;
      seen_q  <= 1'b0;
    end else if (in_fire) begin
      level_q <= level_d;
      seen_q  <= seen_d;
      stack_q <= stack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
    end else if (in_fire) begin
      blk_valid_q <= 1'b1;
    end else if (blk_o.ready) begin
      blk_valid_q <= 1'b0;
    end
  end

  // Hold the word while stalled.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      blk_q <= res;
    end
  end

  assign blk_o.valid           = blk_valid_q;
  assign blk_o.black_block     = blk_q.black_block;
  assign blk_o.block_row       = blk_q.block_row;
  assign blk_o.block_col       = blk_q.block_col;
  assign blk_o.block_side_log2 = blk_q.block_side_log2;
  assign blk_o.image_done      = blk_q.image_done;
  assign blk_o.all_white       = blk_q.all_white;
  assign blk_o.split_error     = blk_q.split_error;

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= lg_q) else $error("tree level beyond image depth");

  a_done_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i && res.image_done) |=> (level_q == '0 && !seen_q))
    else $error("tree not restarted after image close");

  a_split_err_at_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && res.split_error) |-> (level_q == lg_q))
    else $error("split error above pixel level");

  a_white_only_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_o.valid && blk_o.all_white) |-> (blk_o.image_done && !blk_o.black_block))
    else $error("all-white flag without a clean close");

  a_side_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_o.valid && blk_o.black_block) |-> (32'(blk_o.block_side_log2) <= 32'(lg_q)))
    else $error("black block larger than image");

endmodule

FILE: dv/df_expression_quadtree_decoder_tb.sv
`timescale 1ns / 1ps

module df_expression_quadtree_decoder_tb;
  import dfq_pkg::*;

  localparam int MAX_LOG2 = MAX_LOG2_DEF;
  localparam logic [SYM_W-1:0] SYM_SPARE = 2'd3;
  localparam int SYMBOL_TARGET = 1450;
  localparam int PHASE_SYMBOLS = 130;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [SIZE_W-1:0] cfg_data_i;

  dfq_sym_if sym_if ();
  dfq_blk_if blk_if ();

  df_expression_quadtree_decoder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .sym_i      (sym_if),
    .blk_o      (blk_if)
  );

  // decoder shadow state
  logic [QUAD_W-1:0] tree_path [MAX_LOG2];
  int                tree_depth;
  bit                saw_black;
  logic [SIZE_W-1:0] size_reg;

  logic [SYM_W-1:0] symbols_to_send [$];
  blk_t             expected_blocks [$];
  int               mismatches;
  int               symbols_queued;
  bit               steady_flow;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic void clear_tree();
    foreach (tree_path[d]) tree_path[d] = QUAD_FIRST;
    tree_depth = 0;
    saw_black  = 1'b0;
  endfunction

  function automatic blk_t decode_symbol(logic [SYM_W-1:0] sym);
    blk_t r;
    int   lg;
    int   rr;
    int   cc;
    r  = '0;
    rr = 0;
    cc = 0;
    lg = (int'(size_reg) > MAX_LOG2) ? MAX_LOG2 : int'(size_reg);
    if (tree_depth > lg) tree_depth = lg;
    if (sym == SYM_SPLIT && tree_depth < lg) begin
      tree_path[tree_depth] = QUAD_FIRST;
      tree_depth++;
    end else begin
      // a split at pixel level falls through as a white leaf
      if (sym == SYM_SPLIT) r.split_error = 1'b1;
      if (sym == SYM_BLACK) begin
        for (int d = 0; d < tree_depth; d++) begin
          cc |= int'(tree_path[d][0]) << (lg - 1 - d);
          rr |= int'(tree_path[d][1]) << (lg - 1 - d);
        end
        r.black_block     = 1'b1;
        r.block_row       = rr[COORD_W-1:0];
        r.block_col       = cc[COORD_W-1:0];
        r.block_side_log2 = SIDE_W'(lg - tree_depth);
        saw_black         = 1'b1;
      end
      // pop every finished quadrant, then advance to the next sibling
      while (tree_depth > 0 && tree_path[tree_depth-1] == QUAD_LAST) tree_depth--;
      if (tree_depth == 0) begin
        r.image_done = 1'b1;
        r.all_white  = !saw_black;
        clear_tree();
      end else begin
        tree_path[tree_depth-1]++;
      end
    end
    return r;
  endfunction

  // Queue one subtree. A dive forces splits down one random path to pixel level.
  function automatic void grow_tree(int lvl, int lg, bit dive, int black_pct);
    int pick;
    int split_pct;
    split_pct = (lvl == 0) ? 85 : ((lvl < 2) ? 45 : 15);
    if (lvl < lg && (dive || $urandom_range(99) < split_pct)) begin
      pick = $urandom_range(3);
      symbols_to_send.push_back(SYM_SPLIT);
      for (int q = 0; q < 4; q++) grow_tree(lvl + 1, lg, dive && q == pick, black_pct);
    end else if (lvl == lg && $urandom_range(99) < 8) begin
      symbols_to_send.push_back(SYM_SPLIT);
    end else if ($urandom_range(99) < black_pct) begin
      symbols_to_send.push_back(SYM_BLACK);
    end else begin
      symbols_to_send.push_back(($urandom_range(99) < 10) ? SYM_SPARE : SYM_WHITE);
    end
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic wait_idle();
    while (symbols_to_send.size() != 0 || sym_if.valid || expected_blocks.size() != 0)
      @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_size(logic [SIZE_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    size_reg = v;
    clear_tree();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // symbol driver
  always @(posedge clk_i) begin
    bit go;
    if (rst_ni) begin
      if (sym_if.valid && sym_if.ready)
        expected_blocks.push_back(decode_symbol(sym_if.symbol));
      if (!sym_if.valid || sym_if.ready) begin
        go = symbols_to_send.size() != 0 && (steady_flow || $urandom_range(99) >= 25);
        if (go) sym_if.symbol <= symbols_to_send.pop_front();
        sym_if.valid <= go;
      end
    end
  end

  // block word monitor
  always @(posedge clk_i) begin
    blk_t want;
    if (rst_ni) begin
      if (blk_if.valid && blk_if.ready) begin
        if (expected_blocks.size() == 0) begin
          flag_mismatch("word with nothing pending, black_block", blk_if.black_block, 0);
        end else begin
          want = expected_blocks.pop_front();
          if (blk_if.black_block !== want.black_block)
            flag_mismatch("black_block", blk_if.black_block, want.black_block);
          if (blk_if.block_row !== want.block_row)
            flag_mismatch("block_row", blk_if.block_row, want.block_row);
          if (blk_if.block_col !== want.block_col)
            flag_mismatch("block_col", blk_if.block_col, want.block_col);
          if (blk_if.block_side_log2 !== want.block_side_log2)
            flag_mismatch("block_side_log2", blk_if.block_side_log2, want.block_side_log2);
          if (blk_if.image_done !== want.image_done)
            flag_mismatch("image_done", blk_if.image_done, want.image_done);
          if (blk_if.all_white !== want.all_white)
            flag_mismatch("all_white", blk_if.all_white, want.all_white);
          if (blk_if.split_error !== want.split_error)
            flag_mismatch("split_error", blk_if.split_error, want.split_error);
        end
      end
      blk_if.ready <= steady_flow || $urandom_range(99) >= 25;
    end
  end

  initial begin
    logic [SIZE_W-1:0] phase_sizes [8];
    logic [SIZE_W-1:0] sz;
    int                lg;
    int                phase;
    int                pick;
    int                black_pct;
    phase_sizes   = '{4'd10, 4'd15, 4'd1, 4'd3, 4'd2, 4'd11, 4'd5, 4'd0};
    mismatches    = 0;
    symbols_queued = 0;
    steady_flow   = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = '0;
    sym_if.valid  = 1'b0;
    sym_if.symbol = SYM_WHITE;
    blk_if.ready  = 1'b0;
    size_reg      = SIZE_RESET;
    clear_tree();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // whole-image leaves, a full small tree with a pixel-level split, then a partial image
    symbols_to_send = '{SYM_BLACK, SYM_WHITE, SYM_SPARE,
                        SYM_SPLIT, SYM_BLACK, SYM_WHITE, SYM_SPARE, SYM_SPLIT,
                        SYM_BLACK, SYM_BLACK, SYM_SPLIT, SYM_BLACK,
                        SYM_SPLIT, SYM_WHITE, SYM_SPLIT, SYM_BLACK};
    symbols_queued += symbols_to_send.size();
    wait_idle();
    // single-pixel image: every symbol closes it
    write_size(4'd0);
    symbols_to_send = '{SYM_SPLIT, SYM_BLACK, SYM_WHITE, SYM_SPARE};
    symbols_queued += symbols_to_send.size();
    wait_idle();

    phase = 0;
    while (symbols_queued < SYMBOL_TARGET) begin
      sz = (phase < 8) ? phase_sizes[phase] : SIZE_W'($urandom_range(15));
      write_size(sz);
      lg = (int'(sz) > MAX_LOG2) ? MAX_LOG2 : int'(sz);
      steady_flow = (phase == 3);
      while (symbols_to_send.size() < PHASE_SYMBOLS) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          black_pct = ($urandom_range(3) == 0) ? 0 : (($urandom_range(1) == 0) ? 45 : 90);
          grow_tree(0, lg, $urandom_range(99) < 30, black_pct);
        end else begin
          repeat ($urandom_range(6, 1))
            symbols_to_send.push_back(SYM_W'($urandom_range(3)));
        end
      end
      symbols_queued += symbols_to_send.size();
      wait_idle();
      phase++;
    end
    steady_flow = 1'b0;

    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/dfq_pkg.sv
rtl/dfq_sym_if.sv
rtl/dfq_blk_if.sv
rtl/dfq_step.sv
rtl/df_expression_quadtree_decoder.sv
dv/df_expression_quadtree_decoder_tb.sv
